// ===== sv/ptfg_pkg.sv =====
// Package for the polygonal taper filter gain block.
// Shared types, constants and the sin-squared table. No dependencies.
`default_nettype none
package ptfg_pkg;

  localparam int FFT_SIZE_DEF    = 1024;
  localparam int NUM_CORNERS_DEF = 4;
  localparam int QUEUE_DEPTH     = 4;
  localparam int DIV_STEPS       = 16;
  localparam int BIN_W           = 10;
  localparam int AMP_W           = 16;
  localparam int CFG_ADDR_W      = 3;
  localparam int SEG_W           = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_CORNER_A = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CORNER_B = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CORNER_C = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CORNER_D = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_A    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_B    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_C    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_D    = 3'd7;

  typedef struct packed {
    logic [3:0][BIN_W-1:0] corner;
    logic [3:0][AMP_W-1:0] amp;
  } cfg_t;

  // One classified transaction: constant gain, or taper parameters.
  typedef struct packed {
    logic             taper;
    logic             hit;
    logic [AMP_W-1:0] val;
    logic [AMP_W-1:0] diff;
    logic [SEG_W-1:0] m;
    logic [SEG_W-1:0] d;
  } item_t;

  function automatic logic [16:0] sin2(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0:  v = 17'd0;     6'd1:  v = 17'd158;   6'd2:  v = 17'd630;
      6'd3:  v = 17'd1411;  6'd4:  v = 17'd2494;  6'd5:  v = 17'd3869;
      6'd6:  v = 17'd5522;  6'd7:  v = 17'd7438;  6'd8:  v = 17'd9598;
      6'd9:  v = 17'd11980; 6'd10: v = 17'd14563; 6'd11: v = 17'd17321;
      6'd12: v = 17'd20228; 6'd13: v = 17'd23256; 6'd14: v = 17'd26375;
      6'd15: v = 17'd29556; 6'd16: v = 17'd32768; 6'd17: v = 17'd35980;
      6'd18: v = 17'd39161; 6'd19: v = 17'd42280; 6'd20: v = 17'd45308;
      6'd21: v = 17'd48215; 6'd22: v = 17'd50973; 6'd23: v = 17'd53556;
      6'd24: v = 17'd55938; 6'd25: v = 17'd58098; 6'd26: v = 17'd60014;
      6'd27: v = 17'd61667; 6'd28: v = 17'd63042; 6'd29: v = 17'd64125;
      6'd30: v = 17'd64906; 6'd31: v = 17'd65378;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ptfg_front.sv =====
// Front stage: clamps corners and picks the winning segment rule per bin.
// Depends on ptfg_pkg.
`default_nettype none
module ptfg_front #(
  parameter int FFT_SIZE    = ptfg_pkg::FFT_SIZE_DEF,
  parameter int NUM_CORNERS = ptfg_pkg::NUM_CORNERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ptfg_pkg::cfg_t              cfg,
  input  wire logic                        in_push,
  input  wire logic [ptfg_pkg::BIN_W-1:0]  in_bin,
  output logic                             in_full,
  input  wire logic                        q_full,
  output logic                             q_push,
  output ptfg_pkg::item_t                  q_item
);

  localparam int NYQ = FFT_SIZE / 2;
  localparam int NC  = (NUM_CORNERS > 4) ? 4 : ((NUM_CORNERS < 2) ? 2 : NUM_CORNERS);

  logic            vld_r;
  ptfg_pkg::item_t item_r, item_nxt;

  always_comb begin
    logic [3:0][ptfg_pkg::BIN_W-1:0] k;
    logic [ptfg_pkg::BIN_W-1:0] lo, hi;
    logic [ptfg_pkg::AMP_W-1:0] a0, a1;
    logic [ptfg_pkg::SEG_W-1:0] start;
    logic in_seg, tapered;
    for (int j = 0; j < 4; j++) begin
      k[j] = (int'(cfg.corner[j]) > NYQ) ? ptfg_pkg::BIN_W'(NYQ) : cfg.corner[j];
    end
    item_nxt = '0;
    tapered  = 1'b0;
    if (in_bin < k[0]) begin
      item_nxt.hit = 1'b1;
      item_nxt.val = cfg.amp[0];
    end
    for (int s = 0; s < NC - 1; s++) begin
      lo     = k[s];
      hi     = k[s+1];
      a0     = cfg.amp[s];
      a1     = cfg.amp[s+1];
      in_seg = (in_bin >= lo) && (in_bin <= hi);
      start  = tapered ? ({1'b0, lo} + 11'd1) : {1'b0, lo};
      if (a0 != a1) begin
        tapered = 1'b1;
        if (in_seg) begin
          item_nxt.hit   = 1'b1;
          item_nxt.taper = 1'b1;
          item_nxt.val   = (a0 < a1) ? a0 : a1;
          item_nxt.diff  = (a0 < a1) ? (a1 - a0) : (a0 - a1);
          item_nxt.m     = (a0 < a1) ? ({1'b0, in_bin} - {1'b0, lo} + 11'd1)
                                     : ({1'b0, hi} - {1'b0, in_bin} + 11'd1);
          item_nxt.d     = {1'b0, hi} - {1'b0, lo} + 11'd2;
        end
      end else if (({1'b0, in_bin} >= start) && (in_bin <= hi)) begin
        item_nxt.hit   = 1'b1;
        item_nxt.taper = 1'b0;
        item_nxt.val   = a0;
      end
    end
    if ((in_bin > k[NC-1]) && (int'(in_bin) <= NYQ)) begin
      item_nxt.hit   = 1'b1;
      item_nxt.taper = 1'b0;
      item_nxt.val   = cfg.amp[NC-1];
    end
  end

  assign in_full = vld_r && q_full;
  assign q_push  = vld_r && !q_full;
  assign q_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_full) begin
      vld_r <= in_push;
    end
    if (!in_full && in_push) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptfg_queue.sv =====
// Short fall-through queue between front and back stages.
// Depends on ptfg_pkg.
`default_nettype none
module ptfg_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ptfg_pkg::item_t wr_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output ptfg_pkg::item_t      rd_item
);

  localparam int D  = ptfg_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  ptfg_pkg::item_t [D-1:0] ent_r;
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (int'(cnt_r) == D);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (int'(wp_r) == D - 1) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (int'(rp_r) == D - 1) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
    if (do_push) ent_r[wp_r] <= wr_item;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) int'(cnt_r) <= D)
    else $error("queue count overflow");
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || int'(cnt_r) == D) |-> (wp_r == rp_r))
    else $error("queue pointers disagree with count");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance");
`endif

endmodule
`default_nettype wire

// ===== sv/ptfg_back.sv =====
// Back stage: pipelined phase divider, sin-squared interpolation, gain blend.
// Depends on ptfg_pkg.
`default_nettype none
module ptfg_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire ptfg_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [15:0]          out_gain,
  output logic                 out_uncovered
);

  localparam int NS = ptfg_pkg::DIV_STEPS;

  typedef struct packed {
    logic            vld;
    ptfg_pkg::item_t it;
    logic [11:0]     r;
    logic [15:0]     q;
  } div_t;

  typedef struct packed {
    logic            vld;
    ptfg_pkg::item_t it;
    logic [16:0]     s2;
  } int_t;

  typedef struct packed {
    logic            vld;
    ptfg_pkg::item_t it;
    logic [32:0]     prod;
  } mul_t;

  div_t [NS:0] st_r, st_nxt;
  int_t        ip_r, ip_nxt;
  mul_t        mu_r, mu_nxt;
  logic        out_vld_r;
  logic [15:0] gain_r, gain_nxt;
  logic        unc_r;
  logic        adv;

  assign adv   = !out_vld_r || out_pop;
  assign q_pop = adv;

  always_comb begin
    logic [11:0] sh;
    logic [5:0]  idx;
    logic [16:0] t0, t1, dt;
    logic [22:0] dp;
    st_nxt[0].vld = !q_empty;
    st_nxt[0].it  = q_item;
    st_nxt[0].r   = {1'b0, q_item.m};
    st_nxt[0].q   = '0;
    for (int j = 1; j <= NS; j++) begin
      st_nxt[j] = st_r[j-1];
      sh = {st_r[j-1].r[10:0], 1'b0};
      if (sh >= {1'b0, st_r[j-1].it.d}) begin
        st_nxt[j].r = sh - {1'b0, st_r[j-1].it.d};
        st_nxt[j].q = {st_r[j-1].q[14:0], 1'b1};
      end else begin
        st_nxt[j].r = sh;
        st_nxt[j].q = {st_r[j-1].q[14:0], 1'b0};
      end
    end
    idx        = {1'b0, st_r[NS].q[15:11]};
    t0         = ptfg_pkg::sin2(idx);
    t1         = ptfg_pkg::sin2(idx + 6'd1);
    dt         = t1 - t0;
    dp         = 23'(dt[11:0]) * 23'(st_r[NS].q[10:0]);
    ip_nxt.vld = st_r[NS].vld;
    ip_nxt.it  = st_r[NS].it;
    ip_nxt.s2  = t0 + 17'(dp >> 11);
    mu_nxt.vld  = ip_r.vld;
    mu_nxt.it   = ip_r.it;
    mu_nxt.prod = 33'(ip_r.it.diff) * 33'(ip_r.s2);
    if (mu_r.it.taper) begin
      gain_nxt = mu_r.it.val + mu_r.prod[31:16];
    end else begin
      gain_nxt = mu_r.it.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NS; j++) st_r[j].vld <= 1'b0;
      ip_r.vld  <= 1'b0;
      mu_r.vld  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j <= NS; j++) st_r[j].vld <= st_nxt[j].vld;
      ip_r.vld  <= ip_nxt.vld;
      mu_r.vld  <= mu_nxt.vld;
      out_vld_r <= mu_r.vld;
    end
    if (adv) begin
      for (int j = 0; j <= NS; j++) begin
        st_r[j].it <= st_nxt[j].it;
        st_r[j].r  <= st_nxt[j].r;
        st_r[j].q  <= st_nxt[j].q;
      end
      ip_r.it   <= ip_nxt.it;
      ip_r.s2   <= ip_nxt.s2;
      mu_r.it   <= mu_nxt.it;
      mu_r.prod <= mu_nxt.prod;
      gain_r    <= gain_nxt;
      unc_r     <= !mu_r.it.hit;
    end
  end

  assign out_empty     = !out_vld_r;
  assign out_gain      = gain_r;
  assign out_uncovered = unc_r;

endmodule
`default_nettype wire

// ===== sv/polygonal_taper_filter_gain_top.sv =====
// Throughput: one transaction per cycle while no stall holds the pipe; the 16-stage phase divider is pipelined.
// Stalls on the result side freeze the back pipeline; the 4-entry queue absorbs them.
// Reset: synchronous active low; clears configuration to zero and empties the pipe.
// Top level: configuration registers, front, queue and back stages.
// Depends on ptfg_pkg, ptfg_front, ptfg_queue, ptfg_back.
`default_nettype none
module polygonal_taper_filter_gain_top #(
  parameter int FFT_SIZE    = ptfg_pkg::FFT_SIZE_DEF,
  parameter int NUM_CORNERS = ptfg_pkg::NUM_CORNERS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ptfg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [ptfg_pkg::AMP_W-1:0]       cfg_wdata,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [ptfg_pkg::BIN_W-1:0]       in_bin_index,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [ptfg_pkg::AMP_W-1:0]            out_gain,
  output logic                                  out_uncovered
);

  ptfg_pkg::cfg_t  cfg_r;
  ptfg_pkg::item_t f_item, q_rd;
  logic            q_full, q_push, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ptfg_pkg::REG_CORNER_A: cfg_r.corner[0] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
        ptfg_pkg::REG_CORNER_B: cfg_r.corner[1] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
        ptfg_pkg::REG_CORNER_C: cfg_r.corner[2] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
        ptfg_pkg::REG_CORNER_D: cfg_r.corner[3] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
        ptfg_pkg::REG_AMP_A:    cfg_r.amp[0]    <= cfg_wdata;
        ptfg_pkg::REG_AMP_B:    cfg_r.amp[1]    <= cfg_wdata;
        ptfg_pkg::REG_AMP_C:    cfg_r.amp[2]    <= cfg_wdata;
        ptfg_pkg::REG_AMP_D:    cfg_r.amp[3]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ptfg_front #(.FFT_SIZE(FFT_SIZE), .NUM_CORNERS(NUM_CORNERS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_push(push), .in_bin(in_bin_index), .in_full(full),
    .q_full(q_full), .q_push(q_push), .q_item(f_item)
  );

  ptfg_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wr_item(f_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rd_item(q_rd)
  );

  ptfg_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_item(q_rd), .q_pop(q_pop),
    .out_empty(empty), .out_pop(pop),
    .out_gain(out_gain), .out_uncovered(out_uncovered)
  );

endmodule
`default_nettype wire

// ===== test/ptfg_gain_checker.sv =====
// Checker for the polygonal taper filter gain block: tracks configuration writes,
// predicts gain and uncovered flag per accepted bin, compares popped results.
// Depends on ptfg_pkg.
module ptfg_gain_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ptfg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ptfg_pkg::AMP_W-1:0]      cfg_wdata,
  input  logic                            push,
  input  logic                            full,
  input  logic [ptfg_pkg::BIN_W-1:0]      in_bin_index,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [ptfg_pkg::AMP_W-1:0]      out_gain,
  input  logic                            out_uncovered,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NYQ_BIN = ptfg_pkg::FFT_SIZE_DEF / 2;

  typedef struct packed {
    logic [ptfg_pkg::AMP_W-1:0] gain;
    logic                       uncovered;
  } gain_res_t;

  const int sin2_lut[33] = '{
    0, 158, 630, 1411, 2494, 3869, 5522, 7438,
    9598, 11980, 14563, 17321, 20228, 23256, 26375, 29556,
    32768, 35980, 39161, 42280, 45308, 48215, 50973, 53556,
    55938, 58098, 60014, 61667, 63042, 64125, 64906, 65378,
    65536};

  logic [ptfg_pkg::BIN_W-1:0] corner_q [4];
  logic [ptfg_pkg::AMP_W-1:0] amp_q [4];
  gain_res_t                  gain_fifo [$];

  function automatic int taper_value(int low, int diff, int m, int w);
    longint ph;
    int     idx, frac, s2;
    ph = (longint'(m) << 16) / (w + 2);
    if (ph > 65535) ph = 65535;
    idx  = int'(ph >> 11) & 31;
    frac = int'(ph) & 2047;
    s2   = sin2_lut[idx] + (((sin2_lut[idx+1] - sin2_lut[idx]) * frac) >> 11);
    return (low + int'((longint'(diff) * s2) >> 16)) & 16'hFFFF;
  endfunction

  function automatic gain_res_t predict_gain(logic [ptfg_pkg::BIN_W-1:0] bin_in);
    int        b, lo, hi, a0, a1, start, g;
    int        k [4];
    bit        hit, tapered;
    gain_res_t r;
    b = bin_in;
    g = 0;
    hit = 0;
    tapered = 0;
    for (int j = 0; j < 4; j++) k[j] = (corner_q[j] > NYQ_BIN) ? NYQ_BIN : corner_q[j];
    if (b < k[0]) begin
      g = amp_q[0];
      hit = 1;
    end
    for (int s = 0; s < 3; s++) begin
      lo = k[s];
      hi = k[s+1];
      a0 = amp_q[s];
      a1 = amp_q[s+1];
      if (a0 < a1) begin
        tapered = 1;
        if (b >= lo && b <= hi) begin
          g = taper_value(a0, a1 - a0, b - lo + 1, hi - lo);
          hit = 1;
        end
      end else if (a0 > a1) begin
        tapered = 1;
        if (b >= lo && b <= hi) begin
          g = taper_value(a1, a0 - a1, hi - b + 1, hi - lo);
          hit = 1;
        end
      end else begin
        start = tapered ? lo + 1 : lo;
        if (b >= start && b <= hi) begin
          g = a0;
          hit = 1;
        end
      end
    end
    if (b > k[3] && b <= NYQ_BIN) begin
      g = amp_q[3];
      hit = 1;
    end
    r.gain      = hit ? g[ptfg_pkg::AMP_W-1:0] : '0;
    r.uncovered = !hit;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    gain_res_t exp_r;
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) begin
        corner_q[j] <= '0;
        amp_q[j]    <= '0;
      end
      gain_fifo.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ptfg_pkg::REG_CORNER_A: corner_q[0] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
          ptfg_pkg::REG_CORNER_B: corner_q[1] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
          ptfg_pkg::REG_CORNER_C: corner_q[2] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
          ptfg_pkg::REG_CORNER_D: corner_q[3] <= cfg_wdata[ptfg_pkg::BIN_W-1:0];
          ptfg_pkg::REG_AMP_A:    amp_q[0]    <= cfg_wdata;
          ptfg_pkg::REG_AMP_B:    amp_q[1]    <= cfg_wdata;
          ptfg_pkg::REG_AMP_C:    amp_q[2]    <= cfg_wdata;
          ptfg_pkg::REG_AMP_D:    amp_q[3]    <= cfg_wdata;
          default: ;
        endcase
      end
      if (push && !full) gain_fifo.push_back(predict_gain(in_bin_index));
      if (pop && !empty) begin
        if (gain_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected transaction gain=%0d uncovered=%0b",
                     $realtime, out_gain, out_uncovered);
        end else begin
          exp_r = gain_fifo.pop_front();
          if (exp_r.gain !== out_gain || exp_r.uncovered !== out_uncovered) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch gain exp=%0d act=%0d uncovered exp=%0b act=%0b",
                       $realtime, exp_r.gain, out_gain, exp_r.uncovered, out_uncovered);
          end
        end
      end
    end
    pending = gain_fifo.size();
  end

endmodule

// ===== test/tb_polygonal_taper_filter_gain_top.sv =====
// Testbench top for polygonal_taper_filter_gain_top: clock, reset, configuration
// phases, bin stimulus with idling and back-pressure, verdict. Uses ptfg_gain_checker.
module tb_polygonal_taper_filter_gain_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ptfg_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [ptfg_pkg::AMP_W-1:0]      cfg_wdata;
  logic                            push;
  logic                            full;
  logic [ptfg_pkg::BIN_W-1:0]      in_bin_index;
  logic                            empty;
  logic                            pop;
  logic [ptfg_pkg::AMP_W-1:0]      out_gain;
  logic                            out_uncovered;
  int                              fail_count;
  int                              pending;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;
  logic [ptfg_pkg::BIN_W-1:0] corner_set [4];

  polygonal_taper_filter_gain_top dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .push, .full, .in_bin_index,
    .empty, .pop, .out_gain, .out_uncovered
  );

  ptfg_gain_checker checker_i (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .push, .full, .in_bin_index,
    .empty, .pop, .out_gain, .out_uncovered, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    push = 1'b0; in_bin_index = '0; pop = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0; hold_left = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end
  initial cycle_count = 0;

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 200;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_bin(input logic [ptfg_pkg::BIN_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_bin_index <= b;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptfg_pkg::CFG_ADDR_W-1:0] a,
                           input logic [ptfg_pkg::AMP_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [ptfg_pkg::BIN_W-1:0] c [4],
                              input logic [ptfg_pkg::AMP_W-1:0] a [4]);
    write_reg(ptfg_pkg::REG_CORNER_A, ptfg_pkg::AMP_W'(c[0]));
    write_reg(ptfg_pkg::REG_CORNER_B, ptfg_pkg::AMP_W'(c[1]));
    write_reg(ptfg_pkg::REG_CORNER_C, ptfg_pkg::AMP_W'(c[2]));
    write_reg(ptfg_pkg::REG_CORNER_D, ptfg_pkg::AMP_W'(c[3]));
    write_reg(ptfg_pkg::REG_AMP_A, a[0]);
    write_reg(ptfg_pkg::REG_AMP_B, a[1]);
    write_reg(ptfg_pkg::REG_AMP_C, a[2]);
    write_reg(ptfg_pkg::REG_AMP_D, a[3]);
    cfg_we <= 1'b0;
    for (int j = 0; j < 4; j++) corner_set[j] = c[j];
  endtask

  function automatic logic [ptfg_pkg::BIN_W-1:0] random_bin();
    int r, j;
    r = $urandom_range(99);
    j = $urandom_range(3);
    if (r < 40) return ptfg_pkg::BIN_W'(int'(corner_set[j]) + $urandom_range(4) - 2);
    if (r < 50) return ptfg_pkg::BIN_W'($urandom_range(1023));
    return ptfg_pkg::BIN_W'($urandom_range(512));
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_bin(random_bin());
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  initial begin
    logic [ptfg_pkg::BIN_W-1:0] c [4];
    logic [ptfg_pkg::AMP_W-1:0] a [4];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: everything flat at zero
    foreach (c[j]) corner_set[j] = '0;
    send_bin(10'd0); send_bin(10'd1); send_bin(10'd512); send_bin(10'd513);
    send_bin(10'd1023);
    wait_drained();

    // directed: ascending corners; rising taper, flat after taper, rising taper
    c = '{10'd40, 10'd100, 10'd300, 10'd450};
    a = '{16'd0, 16'd32768, 16'd32768, 16'd65535};
    load_setting(c, a);
    foreach (c[j]) begin
      send_bin(c[j] - 1'b1); send_bin(c[j]); send_bin(c[j] + 1'b1);
    end
    send_bin(10'd0); send_bin(10'd512); send_bin(10'd513); send_bin(10'd1023);
    send_bin(10'd700);
    wait_drained();

    // extremes: corners beyond Nyquist clamp, max/min amplitudes, falling and rising
    c = '{10'd0, 10'd1023, 10'd1023, 10'd1023};
    a = '{16'd65535, 16'd0, 16'd0, 16'd65535};
    load_setting(c, a);
    send_bin(10'd0); send_bin(10'd1); send_bin(10'd256); send_bin(10'd511);
    send_bin(10'd512); send_bin(10'd513); send_bin(10'd1023);
    wait_drained();

    // non-ascending corners give empty and overlapping segments
    c = '{10'd300, 10'd100, 10'd400, 10'd200};
    a = '{16'd1000, 16'd1000, 16'd1000, 16'd5000};
    load_setting(c, a);
    send_bin(10'd50); send_bin(10'd150); send_bin(10'd250); send_bin(10'd350);
    send_bin(10'd500);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      set_idling(ph);
      for (int j = 0; j < 4; j++) c[j] = ptfg_pkg::BIN_W'($urandom_range(1023));
      if (ph % 3 != 2) begin
        c.sort();
        if ($urandom_range(1))
          for (int j = 0; j < 4; j++) c[j] = ptfg_pkg::BIN_W'(c[j] % 513);
      end
      for (int j = 0; j < 4; j++) begin
        case ($urandom_range(4))
          0: a[j] = 16'd0;
          1: a[j] = 16'hFFFF;
          2: a[j] = (j > 0) ? a[j-1] : 16'd0;
          default: a[j] = ptfg_pkg::AMP_W'($urandom_range(65535));
        endcase
      end
      load_setting(c, a);
      if (ph == 5) begin
        hold_req = 1;
        run_random(40);
      end
      run_random(100);
      wait_drained();
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
